[design/plsp_pkg.sv]
// ============================================================================
// plsp_pkg: shared types, constants and helpers of the pixel layer splitter
// Payload structs, register indexes, source ids and the RGB565 expansion.
// ============================================================================
`default_nettype none

package plsp_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 9;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LAYER_MODE     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CAPTURE_ENABLE = 3'd4;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] RST_FRAME_WIDTH  = 9'd240;
  localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT = 9'd160;

  // Width of the clamp arithmetic; covers the largest supported frame size
  localparam int unsigned CLAMP_W = 13;

  // Source ids and layer codes
  localparam logic [7:0] SID_LAYER0      = 8'd0;
  localparam logic [7:0] SID_LAYER1      = 8'd1;
  localparam logic [7:0] SID_OBJECT      = 8'd4;
  localparam logic [7:0] SID_FULL_LIMIT  = 8'd5;
  localparam logic [2:0] LAYER_OBJ_THREE = 3'd2;

  // Pixel constants
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // Depth ramp constants
  localparam logic [7:0] DEPTH_FLAT = 8'd128;
  localparam logic [7:0] DEPTH_MAX  = 8'd255;
  localparam int unsigned DIV_STEPS = 8;

  // c*255/31 and c*255/63 as multiply by a scaled reciprocal, shift by 20
  localparam logic [23:0] EXP5_MUL = 24'd8625630;
  localparam logic [23:0] EXP6_MUL = 24'd4244475;

  typedef struct packed {
    logic [31:0] pixel_word;
    logic [7:0]  render_src;
  } plsp_in_t;

  typedef struct packed {
    logic [31:0] color_rgba;
    logic        layer_hit;
    logic [2:0]  layer_index;
    logic [7:0]  depth_value;
    logic        frame_end;
    logic        frame_visible;
  } plsp_out_t;

  // Mode bits handed from the register file to the front end
  typedef struct packed {
    logic pixel_format;
    logic layer_mode;
    logic capture_enable;
  } plsp_mode_t;

  // Classified pixel passed from the front end to the back end
  typedef struct packed {
    logic [31:0] color_rgba;
    logic        layer_hit;
    logic [2:0]  layer_index;
    logic        need_depth;
    logic        frame_end;
    logic        frame_visible;
  } plsp_cls_t;

  function automatic logic [7:0] expand5(input logic [4:0] c);
    logic [28:0] p;
    p = 29'(c) * 29'(EXP5_MUL);
    return p[27:20];
  endfunction

  function automatic logic [7:0] expand6(input logic [5:0] c);
    logic [28:0] p;
    p = 29'(c) * 29'(EXP6_MUL);
    return p[27:20];
  endfunction

  // Zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [CLAMP_W-1:0] clamp_size(input logic [CFG_DATA_W-1:0] v,
                                                      input logic [CLAMP_W-1:0] maxv);
    logic [CLAMP_W-1:0] ext;
    ext = CLAMP_W'(v);
    if (ext == '0) begin
      return CLAMP_W'(1);
    end else if (ext > maxv) begin
      return maxv;
    end
    return ext;
  endfunction

endpackage

`default_nettype wire

[design/plsp_fifo.sv]
// ============================================================================
// plsp_fifo: short queue between front end and back end
// Register-based FIFO; full and empty let each side stall on its own.
// ============================================================================
`default_nettype none

module plsp_fifo #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  head_valid
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];

  // Advance pointers with explicit wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
    else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

[design/plsp_front.sv]
// ============================================================================
// plsp_front: pixel intake and classification
// Converts the pixel, picks the capture layer, tracks raster position and the
// frame visibility flag, and hands a classified entry to the queue.
// ============================================================================
`default_nettype none

module plsp_front #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  input  wire plsp_pkg::plsp_in_t                  in_data,
  input  wire logic                                queue_full,
  input  wire plsp_pkg::plsp_mode_t                mode,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]      width_eff,
  input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]     height_eff,
  output logic                                     in_stall,
  output logic                                     push,
  output plsp_pkg::plsp_cls_t                      cls,
  output logic [$clog2(MAX_HEIGHT)-1:0]            row
);

  localparam int unsigned WW  = $clog2(MAX_WIDTH);
  localparam int unsigned HW  = $clog2(MAX_HEIGHT);
  localparam int unsigned WSW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HSW = $clog2(MAX_HEIGHT + 1);

  logic [WW-1:0] col_r, col_nxt;
  logic [HW-1:0] row_r, row_nxt;
  logic          seen_r, seen_nxt;

  logic [31:0] color;
  logic        visible;
  logic        hit;
  logic [2:0]  idx;
  logic        row_end;
  logic        frm_end;
  logic [7:0]  sid;

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;
  assign sid      = in_data.render_src;

  // Convert to opaque RGBA8888
  always_comb begin
    if (mode.pixel_format) begin
      color = {plsp_pkg::ALPHA_OPAQUE, in_data.pixel_word[23:0]};
    end else begin
      color = {plsp_pkg::ALPHA_OPAQUE,
               plsp_pkg::expand5(in_data.pixel_word[15:11]),
               plsp_pkg::expand6(in_data.pixel_word[10:5]),
               plsp_pkg::expand5(in_data.pixel_word[4:0])};
    end
  end

  assign visible = (color[23:0] != '0);

  // Route by source id
  always_comb begin
    hit = 1'b0;
    idx = '0;
    if (mode.capture_enable) begin
      if (!mode.layer_mode) begin
        if (sid < plsp_pkg::SID_FULL_LIMIT) begin
          hit = 1'b1;
          idx = sid[2:0];
        end
      end else begin
        if (sid inside {plsp_pkg::SID_LAYER0, plsp_pkg::SID_LAYER1}) begin
          hit = 1'b1;
          idx = sid[2:0];
        end else if (sid == plsp_pkg::SID_OBJECT) begin
          hit = 1'b1;
          idx = plsp_pkg::LAYER_OBJ_THREE;
        end
      end
    end
  end

  // Row and frame ends; a count at or past the last position ends it
  assign row_end = (WSW'(col_r) >= (width_eff - WSW'(1)));
  assign frm_end = row_end && (HSW'(row_r) >= (height_eff - HSW'(1)));

  always_comb begin
    cls.color_rgba    = color;
    cls.layer_hit     = hit;
    cls.layer_index   = idx;
    cls.need_depth    = hit && (sid == plsp_pkg::SID_OBJECT);
    cls.frame_end     = frm_end;
    cls.frame_visible = frm_end && (seen_r || visible);
  end

  assign row = row_r;

  // Advance raster position and visibility flag on each transfer
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    seen_nxt = seen_r;
    if (push) begin
      if (frm_end) begin
        col_nxt  = '0;
        row_nxt  = '0;
        seen_nxt = 1'b0;
      end else begin
        seen_nxt = seen_r || visible;
        if (row_end) begin
          col_nxt = '0;
          row_nxt = row_r + HW'(1);
        end else begin
          col_nxt = col_r + WW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      seen_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      seen_r <= seen_nxt;
    end
  end

endmodule

`default_nettype wire

[design/plsp_back.sv]
// ============================================================================
// plsp_back: depth ramp and result stage
// Computes row*255/(height-1) with an 8-step restoring divider, caches it per
// row, and loads the output register from the queue head.
// ============================================================================
`default_nettype none

module plsp_back #(
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             head_valid,
  input  wire plsp_pkg::plsp_cls_t              head_cls,
  input  wire logic [$clog2(MAX_HEIGHT)-1:0]    head_row,
  input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]  height_eff,
  input  wire logic                             cfg_flush,
  output logic                                  pop,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output plsp_pkg::plsp_out_t                   out_data
);

  localparam int unsigned HW  = $clog2(MAX_HEIGHT);
  localparam int unsigned HSW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned NW  = HW + 8;
  localparam int unsigned SW  = $clog2(plsp_pkg::DIV_STEPS);

  typedef enum logic [1:0] {
    ST_READY  = 2'b01,
    ST_DIVIDE = 2'b10
  } back_state_t;

  back_state_t state_r, state_nxt;

  logic [HW-1:0] depth_row_r;
  logic [7:0]    depth_val_r;
  logic          depth_ok_r;
  logic [HW-1:0] rem_r;
  logic [7:0]    nlow_r;
  logic [7:0]    quo_r;
  logic [SW-1:0] step_r;

  logic              out_valid_r;
  plsp_pkg::plsp_out_t out_data_r;

  logic [HSW-1:0] hm1_wide;
  logic [HW-1:0]  hm1;
  logic [NW-1:0]  numer;
  logic [HW:0]    trial;
  logic [HW:0]    trial_diff;
  logic           trial_ge;
  logic [HW-1:0]  rem_step;
  logic           cache_hit;
  logic           out_free;
  logic           miss;
  logic           emit;
  logic           step_last;

  assign hm1_wide  = height_eff - HSW'(1);
  assign hm1       = hm1_wide[HW-1:0];
  assign numer     = {head_row, 8'h00} - NW'(head_row);
  assign cache_hit = depth_ok_r && (depth_row_r == head_row);
  assign out_free  = !out_valid_r || !out_stall;
  assign miss      = (state_r == ST_READY) && head_valid && head_cls.need_depth && !cache_hit;
  assign emit      = (state_r == ST_READY) && head_valid && out_free &&
                     (!head_cls.need_depth || cache_hit);
  assign pop       = emit;
  assign step_last = (step_r == SW'(plsp_pkg::DIV_STEPS - 1));

  // One restoring divide step
  assign trial      = {rem_r, nlow_r[7]};
  assign trial_diff = trial - {1'b0, hm1};
  assign trial_ge   = (trial >= {1'b0, hm1});
  assign rem_step   = trial_ge ? trial_diff[HW-1:0] : trial[HW-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_READY: begin
        if (miss && (height_eff != HSW'(1)) && (head_row < hm1)) begin
          state_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (step_last) begin
          state_nxt = ST_READY;
        end
      end
      default: state_nxt = ST_READY;
    endcase
  end

  // Control state and depth cache
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_READY;
      depth_ok_r  <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_flush) begin
        depth_ok_r <= 1'b0;
      end else if (miss) begin
        // Flat ramp, the last row and rows past it resolve at once
        depth_ok_r <= (height_eff == HSW'(1)) || (head_row >= hm1);
        step_r     <= '0;
      end else if (state_r == ST_DIVIDE) begin
        step_r <= step_r + SW'(1);
        if (step_last) begin
          depth_ok_r <= 1'b1;
        end
      end
    end
  end

  // Divider datapath and cached value
  always_ff @(posedge clk) begin
    if (miss) begin
      depth_row_r <= head_row;
      rem_r       <= numer[NW-1:8];
      nlow_r      <= numer[7:0];
      quo_r       <= '0;
      if (height_eff == HSW'(1)) begin
        depth_val_r <= plsp_pkg::DEPTH_FLAT;
      end else begin
        depth_val_r <= plsp_pkg::DEPTH_MAX;
      end
    end else if (state_r == ST_DIVIDE) begin
      rem_r  <= rem_step;
      nlow_r <= {nlow_r[6:0], 1'b0};
      quo_r  <= {quo_r[6:0], trial_ge};
      if (step_last) begin
        depth_val_r <= {quo_r[6:0], trial_ge};
      end
    end
  end

  // Output register: load on pop, drop valid once the result is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.color_rgba    <= head_cls.color_rgba;
      out_data_r.layer_hit     <= head_cls.layer_hit;
      out_data_r.layer_index   <= head_cls.layer_index;
      out_data_r.depth_value   <= head_cls.need_depth ? depth_val_r : 8'h00;
      out_data_r.frame_end     <= head_cls.frame_end;
      out_data_r.frame_visible <= head_cls.frame_visible;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_div_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVIDE) |-> (head_valid && head_cls.need_depth))
    else $error("divider running without an object pixel at the queue head");
  a_depth_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && head_cls.need_depth) |-> (depth_ok_r && (depth_row_r == head_row)))
    else $error("object pixel released before its row depth is known");
`endif

endmodule

`default_nettype wire

[design/pixel_layer_splitter.sv]
// ============================================================================
// pixel_layer_splitter: per-pixel color conversion and capture layer router
// Register file and top level; joins the front end, queue and back end.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall | plsp_in_t  (pixel_word, render_src)
//   out_    | output    | out_valid/out_stall | plsp_out_t (color .. frame_visible)
//   cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
// One pixel per cycle while no depth divide is pending and the output is not
// stalled; each pixel passes through the queue and then the output register
// before out_valid rises. The first object pixel of a row whose depth is not
// cached waits in the 8-step restoring divider (a one-row frame, or the last
// row and beyond, only loads the cache and skips the divide). Reset is synchronous
// and needs no clearing pass.
// A stalled output holds; the 2-entry queue keeps accepting until it fills.
// ============================================================================
`default_nettype none

module pixel_layer_splitter #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire plsp_pkg::plsp_in_t                     in_data,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output plsp_pkg::plsp_out_t                         out_data,
  input  wire logic                                   cfg_we,
  input  wire logic [plsp_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  wire logic [plsp_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  localparam int unsigned HW  = $clog2(MAX_HEIGHT);
  localparam int unsigned WSW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HSW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned EW  = $bits(plsp_pkg::plsp_cls_t) + HW;

  logic                              fmt_r;
  logic [plsp_pkg::CFG_DATA_W-1:0]   width_r;
  logic [plsp_pkg::CFG_DATA_W-1:0]   height_r;
  logic                              mode_r;
  logic                              cap_r;

  logic [plsp_pkg::CLAMP_W-1:0] width_clamp;
  logic [plsp_pkg::CLAMP_W-1:0] height_clamp;
  logic [WSW-1:0]               width_eff;
  logic [HSW-1:0]               height_eff;
  plsp_pkg::plsp_mode_t         mode;

  logic                 push;
  logic                 queue_full;
  plsp_pkg::plsp_cls_t  front_cls;
  logic [HW-1:0]        front_row;
  logic [EW-1:0]        head_entry;
  logic                 head_valid;
  logic                 pop;
  plsp_pkg::plsp_cls_t  head_cls;
  logic [HW-1:0]        head_row;

  // Register file; writes to unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= 1'b0;
      width_r  <= plsp_pkg::RST_FRAME_WIDTH;
      height_r <= plsp_pkg::RST_FRAME_HEIGHT;
      mode_r   <= 1'b0;
      cap_r    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        plsp_pkg::REG_PIXEL_FORMAT:   fmt_r    <= cfg_wdata[0];
        plsp_pkg::REG_FRAME_WIDTH:    width_r  <= cfg_wdata;
        plsp_pkg::REG_FRAME_HEIGHT:   height_r <= cfg_wdata;
        plsp_pkg::REG_LAYER_MODE:     mode_r   <= cfg_wdata[0];
        plsp_pkg::REG_CAPTURE_ENABLE: cap_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Clamp frame size into 1..max
  assign width_clamp  = plsp_pkg::clamp_size(width_r, plsp_pkg::CLAMP_W'(MAX_WIDTH));
  assign height_clamp = plsp_pkg::clamp_size(height_r, plsp_pkg::CLAMP_W'(MAX_HEIGHT));
  assign width_eff    = width_clamp[WSW-1:0];
  assign height_eff   = height_clamp[HSW-1:0];

  always_comb begin
    mode.pixel_format   = fmt_r;
    mode.layer_mode     = mode_r;
    mode.capture_enable = cap_r;
  end

  plsp_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .queue_full (queue_full),
    .mode       (mode),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .in_stall   (in_stall),
    .push       (push),
    .cls        (front_cls),
    .row        (front_row)
  );

  plsp_fifo #(
    .WIDTH (EW),
    .DEPTH (2)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  ({front_cls, front_row}),
    .full       (queue_full),
    .pop        (pop),
    .pop_data   (head_entry),
    .head_valid (head_valid)
  );

  assign head_cls = head_entry[EW-1:HW];
  assign head_row = head_entry[HW-1:0];

  plsp_back #(
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cls   (head_cls),
    .head_row   (head_row),
    .height_eff (height_eff),
    .cfg_flush  (cfg_we),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

[sim/tb.sv]
// ============================================================================
// tb: self-checking testbench for the pixel layer splitter
// Drives pixels with source ids through the valid/stall input channel and
// checks every result against an in-bench model of the color conversion,
// layer routing, depth ramp and frame counters. Stimulus is a short directed
// set followed by random frames under many register settings, first with
// heavy output stalls, then with heavy input gaps, then at full rate.
// ============================================================================
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic FMT_RGB565   = 1'b0;
  localparam logic FMT_XRGB8888 = 1'b1;
  localparam logic MODE_FIVE    = 1'b0;
  localparam logic MODE_THREE   = 1'b1;
  localparam logic [7:0] SID_UNKNOWN = 8'd255;
  localparam int unsigned REG_COUNT = 5;
  localparam int unsigned MAX_SIZE  = 256;
  localparam int unsigned ITEMS_PER_PHASE = 430;

  // Model of the splitter plus the store of expected results
  class layer_scoreboard;
    logic        fmt;
    logic [8:0]  width;
    logic [8:0]  height;
    logic        mode;
    logic        cap;
    int unsigned col;
    int unsigned row;
    logic        seen;
    plsp_pkg::plsp_out_t expected_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned frames;
    int unsigned routed;

    function void reset_state();
      fmt = FMT_RGB565;
      width = plsp_pkg::RST_FRAME_WIDTH;
      height = plsp_pkg::RST_FRAME_HEIGHT;
      mode = MODE_FIVE;
      cap = 1'b1;
      col = 0;
      row = 0;
      seen = 1'b0;
      expected_q.delete();
    endfunction

    function void write_reg(logic [plsp_pkg::CFG_INDEX_W-1:0] idx,
                            logic [plsp_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        plsp_pkg::REG_PIXEL_FORMAT:   fmt = val[0];
        plsp_pkg::REG_FRAME_WIDTH:    width = val;
        plsp_pkg::REG_FRAME_HEIGHT:   height = val;
        plsp_pkg::REG_LAYER_MODE:     mode = val[0];
        plsp_pkg::REG_CAPTURE_ENABLE: cap = val[0];
        default: ;
      endcase
    endfunction

    // Zero acts as one, oversize acts as the maximum
    function int unsigned eff_size(logic [8:0] v);
      if (v == 0) return 1;
      if (v > MAX_SIZE) return MAX_SIZE;
      return 32'(v);
    endfunction

    function plsp_pkg::plsp_out_t predict(plsp_pkg::plsp_in_t px);
      int unsigned w, h, r, g, b, depth;
      logic row_end, vis;
      plsp_pkg::plsp_out_t o;
      w = eff_size(width);
      h = eff_size(height);
      o = '0;
      // Convert to opaque RGBA8888
      if (fmt == FMT_XRGB8888) begin
        o.color_rgba = {plsp_pkg::ALPHA_OPAQUE, px.pixel_word[23:0]};
      end else begin
        r = 32'(px.pixel_word[15:11]);
        g = 32'(px.pixel_word[10:5]);
        b = 32'(px.pixel_word[4:0]);
        r = r * 255 / 31;
        g = g * 255 / 63;
        b = b * 255 / 31;
        o.color_rgba = {plsp_pkg::ALPHA_OPAQUE, r[7:0], g[7:0], b[7:0]};
      end
      // Depth ramp of the current row
      if (h <= 1) begin
        depth = 32'(plsp_pkg::DEPTH_FLAT);
      end else begin
        depth = row * 32'(plsp_pkg::DEPTH_MAX) / (h - 1);
        if (depth > 32'(plsp_pkg::DEPTH_MAX)) depth = 32'(plsp_pkg::DEPTH_MAX);
      end
      // Route by source id
      if (cap) begin
        if (mode == MODE_FIVE) begin
          if (px.render_src < plsp_pkg::SID_FULL_LIMIT) begin
            o.layer_hit = 1'b1;
            o.layer_index = px.render_src[2:0];
          end
        end else if (px.render_src == plsp_pkg::SID_LAYER0 ||
                     px.render_src == plsp_pkg::SID_LAYER1) begin
          o.layer_hit = 1'b1;
          o.layer_index = px.render_src[2:0];
        end else if (px.render_src == plsp_pkg::SID_OBJECT) begin
          o.layer_hit = 1'b1;
          o.layer_index = plsp_pkg::LAYER_OBJ_THREE;
        end
        if (o.layer_hit && px.render_src == plsp_pkg::SID_OBJECT)
          o.depth_value = depth[7:0];
      end
      if (o.layer_hit) routed++;
      // Advance position and visibility
      vis = (o.color_rgba[23:0] != 0);
      row_end = (col >= w - 1);
      o.frame_end = row_end && (row >= h - 1);
      if (o.frame_end) begin
        o.frame_visible = seen | vis;
        seen = 1'b0;
        col = 0;
        row = 0;
        frames++;
      end else begin
        seen = seen | vis;
        if (row_end) begin
          col = 0;
          row = row + 1;
        end else begin
          col = col + 1;
        end
      end
      return o;
    endfunction

    function void note_pixel(plsp_pkg::plsp_in_t px);
      expected_q.push_back(predict(px));
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(plsp_pkg::plsp_out_t got);
      plsp_pkg::plsp_out_t want;
      if (expected_q.size() == 0) begin
        report("unexpected result", got.color_rgba, 32'd0);
      end else begin
        want = expected_q.pop_front();
        checked++;
        if (got.color_rgba !== want.color_rgba)
          report("color_rgba", got.color_rgba, want.color_rgba);
        if (got.layer_hit !== want.layer_hit)
          report("layer_hit", 32'(got.layer_hit), 32'(want.layer_hit));
        if (got.layer_index !== want.layer_index)
          report("layer_index", 32'(got.layer_index), 32'(want.layer_index));
        if (got.depth_value !== want.depth_value)
          report("depth_value", 32'(got.depth_value), 32'(want.depth_value));
        if (got.frame_end !== want.frame_end)
          report("frame_end", 32'(got.frame_end), 32'(want.frame_end));
        if (got.frame_visible !== want.frame_visible)
          report("frame_visible", 32'(got.frame_visible), 32'(want.frame_visible));
      end
    endtask
  endclass

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  plsp_pkg::plsp_in_t               in_data = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  plsp_pkg::plsp_out_t              out_data;
  logic                             cfg_we = 1'b0;
  logic [plsp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [plsp_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  layer_scoreboard sb = new();
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned n_sent = 0;
  int unsigned n_settings = 0;

  pixel_layer_splitter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Note each transfer on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_pixel(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // Random receiver stalls
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  // Hold valid and payload until the transfer
  task automatic drive_pixel(logic [31:0] word, logic [7:0] sid);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {word, sid};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    n_sent++;
  endtask

  // Drop valid and wait for every expected result
  task automatic wait_idle();
    int unsigned guard;
    guard = 0;
    in_valid <= 1'b0;
    while (sb.pending() != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
  endtask

  task automatic write_reg(logic [plsp_pkg::CFG_INDEX_W-1:0] idx,
                           logic [plsp_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  // Write all registers; one-bit registers get junk in the upper bits
  task automatic apply_config(logic fmt, logic [8:0] w, logic [8:0] h, logic mode,
                              logic cap);
    wait_idle();
    if ($urandom_range(3) == 0)
      write_reg(plsp_pkg::CFG_INDEX_W'($urandom_range(7, REG_COUNT)),
                plsp_pkg::CFG_DATA_W'($urandom));
    write_reg(plsp_pkg::REG_PIXEL_FORMAT, {8'($urandom), fmt});
    write_reg(plsp_pkg::REG_FRAME_WIDTH, w);
    write_reg(plsp_pkg::REG_FRAME_HEIGHT, h);
    write_reg(plsp_pkg::REG_LAYER_MODE, {8'($urandom), mode});
    write_reg(plsp_pkg::REG_CAPTURE_ENABLE, {8'($urandom), cap});
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // One random setting followed by frames of random pixels, at most budget
  task automatic run_epoch(input int unsigned budget, output int unsigned sent);
    int unsigned kind, we, he, n, i;
    logic [8:0]  wr, hr;
    logic        fmt, dark;
    logic [31:0] word;
    logic [7:0]  sid;
    kind = $urandom_range(9);
    if (kind == 0) begin
      case ($urandom_range(2))
        0: wr = 9'd256;
        1: wr = 9'd300;
        default: wr = 9'd511;
      endcase
      hr = 9'($urandom_range(2, 1));
    end else if (kind == 1) begin
      wr = 9'($urandom_range(1));
      case ($urandom_range(3))
        0: hr = 9'd255;
        1: hr = 9'd256;
        2: hr = 9'd400;
        default: hr = 9'd511;
      endcase
    end else begin
      wr = ($urandom_range(11) == 0) ? 9'd0 : 9'($urandom_range(6, 1));
      hr = ($urandom_range(11) == 0) ? 9'd0 : 9'($urandom_range(6, 1));
    end
    fmt = 1'($urandom_range(1));
    apply_config(fmt, wr, hr, $urandom_range(1) ? MODE_THREE : MODE_FIVE,
                 $urandom_range(4) != 0);
    we = sb.eff_size(wr);
    he = sb.eff_size(hr);
    if (kind < 2) n = we * he + $urandom_range(4);
    else n = we * he * $urandom_range(3, 1) + $urandom_range(we);
    if (n > budget) n = budget;
    dark = ($urandom_range(3) == 0);
    for (i = 0; i < n; i++) begin
      word = $urandom;
      case ($urandom_range(9))
        0: word = 32'h0;
        1: word = 32'hFFFF_FFFF;
        default: ;
      endcase
      if (dark && $urandom_range(29) != 0)
        word = (fmt == FMT_XRGB8888) ? (word & 32'hFF00_0000) : (word & 32'hFFFF_0000);
      case ($urandom_range(9))
        0: sid = 8'($urandom_range(255));
        1: sid = SID_UNKNOWN;
        default: sid = 8'($urandom_range(5));
      endcase
      drive_pixel(word, sid);
    end
    sent = n;
  endtask

  initial begin
    #(2_000_000);
    $display("status: fail");
    $finish;
  end

  initial begin
    int unsigned phase, count, got;
    sb.reset_state();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    send_idle = 20;
    recv_idle = 86;

    // Reset settings: RGB565, 240x160, five layers, capture on
    drive_pixel(32'h0000_0000, plsp_pkg::SID_LAYER0);
    drive_pixel(32'h0000_FFFF, plsp_pkg::SID_OBJECT);
    drive_pixel(32'hABCD_8410, SID_UNKNOWN);

    // Channel extremes and every id in five-layer mode; size shrinks mid-frame
    apply_config(FMT_RGB565, 9'd4, 9'd3, MODE_FIVE, 1'b1);
    drive_pixel(32'h0000_0000, 8'd0);
    drive_pixel(32'h0000_FFFF, 8'd1);
    drive_pixel(32'h0000_F800, 8'd2);
    drive_pixel(32'h0000_07E0, 8'd3);
    drive_pixel(32'h0000_001F, 8'd4);
    drive_pixel(32'hFFFF_0000, 8'd5);
    drive_pixel(32'h1234_5678, SID_UNKNOWN);
    drive_pixel(32'h0000_FFFF, 8'd4);
    drive_pixel(32'h0000_0821, 8'd4);
    drive_pixel(32'hFFFF_FFFF, 8'd4);
    drive_pixel(32'h0000_0000, 8'd0);
    drive_pixel(32'h0000_7BEF, 8'd4);

    // XRGB8888, one-row frames, three-layer mode: black and visible frames
    apply_config(FMT_XRGB8888, 9'd2, 9'd1, MODE_THREE, 1'b1);
    drive_pixel(32'h0000_0000, plsp_pkg::SID_OBJECT);
    drive_pixel(32'hFF00_0000, plsp_pkg::SID_OBJECT);
    drive_pixel(32'hFFFF_FFFF, 8'd2);
    drive_pixel(32'h0000_0001, plsp_pkg::SID_LAYER1);
    drive_pixel(32'h00FF_FFFF, 8'd3);
    drive_pixel(32'h8000_0000, plsp_pkg::SID_LAYER0);

    // Capture off with zero sizes acting as one
    apply_config(FMT_XRGB8888, 9'd0, 9'd0, MODE_FIVE, 1'b0);
    drive_pixel(32'h00FF_FFFF, plsp_pkg::SID_OBJECT);
    drive_pixel(32'h0000_0000, plsp_pkg::SID_LAYER0);
    drive_pixel(32'h0080_0000, SID_UNKNOWN);

    // Random frames: receiver-heavy stalls, sender-heavy gaps, then full rate
    for (phase = 0; phase < 3; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          send_idle = 20;
          recv_idle = 86;
        end
        1: begin
          send_idle = 86;
          recv_idle = 20;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      count = 0;
      while (count < ITEMS_PER_PHASE) begin
        run_epoch(ITEMS_PER_PHASE - count, got);
        count += got;
      end
    end

    // Drain and let any stray result show up
    wait_idle();
    repeat (16) @(negedge clk);
    if (sb.pending() != 0) sb.report("results never delivered", 32'd0, sb.pending());

    $display("covered %0d pixels over %0d register settings, %0d results checked",
             n_sent, n_settings, sb.checked);
    $display("%0d frame ends and %0d routed pixels seen, %0d mismatches",
             sb.frames, sb.routed, sb.errors);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
